@@ rtl/core/deflate_symbol_bit_packer_unit_macros.svh @@
// assertion macros used by the bit packer rtl
`ifndef DEFLATE_SYMBOL_BIT_PACKER_UNIT_MACROS_SVH
`define DEFLATE_SYMBOL_BIT_PACKER_UNIT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define DSBP_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition that holds on the clock after a trigger
`define DSBP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/dsbp_pkg.sv @@
// shared types and constants of the deflate symbol bit packer
package dsbp_pkg;

	localparam int MAX_CODE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int LITLEN_SYMBOLS = 286;
	localparam int DIST_SYMBOLS = 30;

	localparam logic [8:0] END_SYMBOL = 9'd256;
	localparam logic [8:0] FIRST_LEN_SYMBOL = 9'd257;
	localparam logic [8:0] LAST_LEN_SYMBOL = 9'd285;

	localparam int SEG_W = 16;
	localparam int SEG_LEN_W = 5;
	localparam int TOT_MAX = 2 * SEG_W + 18;
	localparam int TOT_W = $clog2(TOT_MAX + 1);
	localparam int BUF_W = 2 * SEG_W;
	localparam int BUF_CNT_W = $clog2(BUF_W + 1);
	localparam int LEFT_W = $clog2(BUF_W + TOT_MAX + 1);

	typedef enum logic [2:0] {
		OP_LOAD_LIT  = 3'd0,
		OP_LOAD_DIST = 3'd1,
		OP_LITERAL   = 3'd2,
		OP_MATCH     = 3'd3,
		OP_END       = 3'd4
	} op_e;

	typedef struct packed {
		logic [2:0]  operation;
		logic [8:0]  table_index;
		logic [15:0] entry_code;
		logic [4:0]  entry_length;
		logic [7:0]  literal_byte;
		logic [7:0]  match_length_minus3;
		logic [15:0] match_distance;
	} token_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [SEG_W-1:0]     val;
		logic [SEG_LEN_W-1:0] len;
	} seg_t;

	typedef struct packed {
		seg_t [3:0]       seg;
		logic             pad;
		logic [TOT_W-1:0] total;
	} desc_t;

endpackage

@@ rtl/core/dsbp_front.sv @@
// front end: code table storage, symbol mapping and bit segment descriptors
module dsbp_front import dsbp_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  token_t token,
	output logic   desc_valid,
	input  logic   desc_ready,
	output desc_t  desc
);

	localparam int ENT_LEN_W = $clog2(MAX_CODE_BITS + 1);
	localparam int ENT_W = MAX_CODE_BITS + ENT_LEN_W;

	function automatic logic [3:0] msb_pos16(input logic [15:0] v);
		logic [3:0] p;
		p = '0;
		for (int i = 1; i < 16; i++) begin
			if (v[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

	logic [ENT_W-1:0] lit_mem [LITLEN_SYMBOLS];
	logic [ENT_W-1:0] dist_mem [DIST_SYMBOLS];

	logic                     accept;
	logic                     emits;
	logic [ENT_LEN_W-1:0]     len_c;
	logic [MAX_CODE_BITS-1:0] code_c;
	logic [7:0]               lm3;
	logic [3:0]               lp;
	logic [8:0]               lit_addr;
	logic [8:0]               lsym;
	logic [2:0]               lx_n;
	logic [4:0]               lx_v;
	logic [15:0]              dist_c;
	logic [14:0]              d;
	logic [3:0]               dq;
	logic [4:0]               dsym;
	logic [3:0]               dx_n;
	logic [12:0]              dx_v;

	logic             v_s1;
	op_e              op_s1;
	logic [2:0]       lx_n_s1;
	logic [4:0]       lx_v_s1;
	logic [3:0]       dx_n_s1;
	logic [12:0]      dx_v_s1;
	logic [ENT_W-1:0] lit_rd_s1;
	logic [ENT_W-1:0] dist_rd_s1;

	assign full = v_s1 && !desc_ready;
	assign accept = push && !full;
	assign desc_valid = v_s1;

	always_comb begin
		emits = token.operation inside {OP_LITERAL, OP_MATCH, OP_END};
		len_c = (token.entry_length > 5'(MAX_CODE_BITS)) ? ENT_LEN_W'(MAX_CODE_BITS)
			: ENT_LEN_W'(token.entry_length);
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			code_c[i] = token.entry_code[i] && (5'(i) < token.entry_length);
		end
	end

	// length symbol and extra bits
	always_comb begin
		lm3 = token.match_length_minus3;
		lp = msb_pos16({8'd0, lm3});
		if (lm3 == 8'd255) begin
			lsym = LAST_LEN_SYMBOL;
			lx_n = '0;
			lx_v = '0;
		end else if (lm3 < 8'd8) begin
			lsym = FIRST_LEN_SYMBOL + 9'(lm3);
			lx_n = '0;
			lx_v = '0;
		end else begin
			lx_n = 3'(lp - 4'd2);
			lsym = FIRST_LEN_SYMBOL + 9'({lp - 4'd1, 2'b00}) + 9'(2'(lm3 >> lx_n));
			lx_v = 5'(lm3 & ((8'd1 << lx_n) - 8'd1));
		end
		case (token.operation)
			OP_MATCH: lit_addr = lsym;
			OP_END:   lit_addr = END_SYMBOL;
			default:  lit_addr = 9'(token.literal_byte);
		endcase
	end

	// distance symbol and extra bits
	always_comb begin
		if (token.match_distance == 16'd0) begin
			dist_c = 16'd1;
		end else if (token.match_distance > 16'd32768) begin
			dist_c = 16'd32768;
		end else begin
			dist_c = token.match_distance;
		end
		d = 15'(dist_c - 16'd1);
		dq = msb_pos16({1'b0, d});
		if (d < 15'd4) begin
			dsym = 5'(d);
			dx_n = '0;
			dx_v = '0;
		end else begin
			dx_n = dq - 4'd1;
			dsym = 5'({dq, 1'b0}) + 5'(d[dx_n]);
			dx_v = 13'(d & ((15'd1 << dx_n) - 15'd1));
		end
	end

	always_ff @(posedge clk) begin
		if (accept && token.operation == OP_LOAD_LIT && token.table_index < 9'(LITLEN_SYMBOLS)) begin
			lit_mem[token.table_index] <= {len_c, code_c};
		end
		if (accept) begin
			lit_rd_s1 <= lit_mem[lit_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && token.operation == OP_LOAD_DIST && token.table_index < 9'(DIST_SYMBOLS)) begin
			dist_mem[token.table_index[4:0]] <= {len_c, code_c};
		end
		if (accept) begin
			dist_rd_s1 <= dist_mem[dsym];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= emits;
		end else if (desc_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_e'(token.operation);
			lx_n_s1 <= lx_n;
			lx_v_s1 <= lx_v;
			dx_n_s1 <= dx_n;
			dx_v_s1 <= dx_v;
		end
	end

	always_comb begin
		desc = '0;
		desc.seg[0].val = SEG_W'(lit_rd_s1[MAX_CODE_BITS-1:0]);
		desc.seg[0].len = SEG_LEN_W'(lit_rd_s1[ENT_W-1 -: ENT_LEN_W]);
		if (op_s1 == OP_MATCH) begin
			desc.seg[1].val = SEG_W'(lx_v_s1);
			desc.seg[1].len = SEG_LEN_W'(lx_n_s1);
			desc.seg[2].val = SEG_W'(dist_rd_s1[MAX_CODE_BITS-1:0]);
			desc.seg[2].len = SEG_LEN_W'(dist_rd_s1[ENT_W-1 -: ENT_LEN_W]);
			desc.seg[3].val = SEG_W'(dx_v_s1);
			desc.seg[3].len = SEG_LEN_W'(dx_n_s1);
		end
		desc.pad = (op_s1 == OP_END);
		desc.total = TOT_W'(desc.seg[0].len) + TOT_W'(desc.seg[1].len)
			+ TOT_W'(desc.seg[2].len) + TOT_W'(desc.seg[3].len);
	end

endmodule

@@ rtl/core/dsbp_fifo.sv @@
// descriptor queue between the front end and the packer
module dsbp_fifo import dsbp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  desc_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output desc_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end

endmodule

@@ rtl/core/dsbp_packer.sv @@
// back end: appends bit segments msb first and emits packed bytes
`include "deflate_symbol_bit_packer_unit_macros.svh"
module dsbp_packer import dsbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    desc_valid,
	output logic    desc_ready,
	input  desc_t   desc,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	localparam int FIT_W = BUF_CNT_W + 1;

	logic                 active_q;
	seg_t [3:0]           segs_q;
	logic [1:0]           ptr_q;
	logic [TOT_W-1:0]     rem_q;
	logic                 pad_q;
	logic [BUF_W-1:0]     buf_q;
	logic [BUF_CNT_W-1:0] cnt_q;
	logic                 out_v_q;
	result_t              out_q;

	logic                 out_free;
	logic                 done;
	logic                 emit_full;
	logic                 emit_pad;
	logic [LEFT_W-1:0]    left;
	logic                 byte_last;
	logic [BUF_W-1:0]     buf_e;
	logic [BUF_CNT_W-1:0] cnt_e;
	seg_t                 cur;
	logic                 fits;
	logic                 do_app;
	logic                 skip;
	logic [BUF_CNT_W-1:0] sh;
	logic [BUF_W-1:0]     buf_n;
	logic [BUF_CNT_W-1:0] cnt_n;

	assign empty = !out_v_q;
	assign result = out_q;
	assign desc_ready = done;

	always_comb begin
		out_free = !out_v_q || pop;
		done = !active_q || (rem_q == '0 && cnt_q < BUF_CNT_W'(8) && !(pad_q && cnt_q != '0));
		emit_full = active_q && cnt_q >= BUF_CNT_W'(8) && out_free;
		emit_pad = active_q && pad_q && rem_q == '0 && cnt_q != '0 && cnt_q < BUF_CNT_W'(8)
			&& out_free;
		left = LEFT_W'(cnt_q) + LEFT_W'(rem_q) - LEFT_W'(8);
		byte_last = emit_pad || (left < LEFT_W'(8) && !(pad_q && left != '0));
		buf_e = (emit_full || emit_pad) ? (buf_q << 8) : buf_q;
		if (emit_full) begin
			cnt_e = cnt_q - BUF_CNT_W'(8);
		end else if (emit_pad) begin
			cnt_e = '0;
		end else begin
			cnt_e = cnt_q;
		end
		cur = segs_q[ptr_q];
		fits = (FIT_W'(cnt_e) + FIT_W'(cur.len)) <= FIT_W'(BUF_W);
		do_app = active_q && rem_q != '0 && cur.len != '0 && fits;
		skip = active_q && rem_q != '0 && cur.len == '0;
		sh = BUF_CNT_W'(BUF_W) - cnt_e - BUF_CNT_W'(cur.len);
		buf_n = do_app ? (buf_e | (BUF_W'(cur.val) << sh)) : buf_e;
		cnt_n = do_app ? (cnt_e + BUF_CNT_W'(cur.len)) : cnt_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ptr_q <= '0;
			rem_q <= '0;
			buf_q <= '0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (done) begin
				active_q <= desc_valid;
				if (desc_valid) begin
					ptr_q <= '0;
					rem_q <= desc.total;
				end
			end else begin
				buf_q <= buf_n;
				cnt_q <= cnt_n;
				if (do_app || skip) begin
					ptr_q <= ptr_q + 2'd1;
				end
				if (do_app) begin
					rem_q <= rem_q - TOT_W'(cur.len);
				end
			end
			if (emit_full || emit_pad) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && desc_valid) begin
			segs_q <= desc.seg;
			pad_q <= desc.pad;
		end
		if (emit_full || emit_pad) begin
			out_q.out_byte <= buf_q[BUF_W-1 -: 8];
			out_q.last <= byte_last;
		end
	end

	`DSBP_ASSERT(a_cnt_bound, cnt_q <= BUF_CNT_W'(BUF_W), "bit count beyond buffer")
	`DSBP_ASSERT(a_low_bits_clear, (buf_q << cnt_q) == '0, "stale bits below fill level")
	`DSBP_ASSERT(a_idle_no_bits, active_q || rem_q == '0, "pending bits with no active beat")
	`DSBP_ASSERT_NEXT(a_pad_last, emit_pad, cnt_q == '0 && out_v_q && out_q.last, "pad beat not last")

endmodule

@@ rtl/core/deflate_symbol_bit_packer_unit.sv @@
// top level of the deflate symbol bit packer
// usage:
//   input queue: a token beat is taken on a clock edge with push high and full low;
//   load operations write the literal/length or distance code table, literal,
//   match and end block operations produce packed bytes
//   result queue: while empty is low the oldest byte and its last flag are on
//   result; it is taken on a clock edge with pop high
//   last marks the final byte caused by one token; tokens that cause no byte
//   give no result
//   a token's bytes pass the lookup register, the descriptor queue, the packer
//   accumulator and the byte-wide output register
//   throughput: a token beat can enter every cycle while full is low; the
//   packer then picks up a token, appends one code or extra-bits segment per
//   cycle while it fits and emits one byte per cycle while the output is free
//   a descriptor queue between table lookup and packer lets both sides stall
//   on their own; when pop stays low the packer holds and full rises once the
//   queue and the lookup stage are occupied
//   reset clears the bit accumulator and all queues; the code tables keep no
//   reset value and must be loaded before use
module deflate_symbol_bit_packer_unit import dsbp_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  token_t  token,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic  fr_valid;
	logic  fr_ready;
	desc_t fr_desc;
	logic  bk_valid;
	logic  bk_ready;
	desc_t bk_desc;

	dsbp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.token(token),
		.desc_valid(fr_valid),
		.desc_ready(fr_ready),
		.desc(fr_desc)
	);

	dsbp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fr_valid),
		.wr_ready(fr_ready),
		.wr_data(fr_desc),
		.rd_valid(bk_valid),
		.rd_ready(bk_ready),
		.rd_data(bk_desc)
	);

	dsbp_packer u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.desc_valid(bk_valid),
		.desc_ready(bk_ready),
		.desc(bk_desc),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
